// ===== design/rdsge_pkg.sv =====
package rdsge_pkg;

  // item kinds carried on s_tuser
  localparam logic [1:0] OP_NAME = 2'd0;
  localparam logic [1:0] OP_TEXT = 2'd1;
  localparam logic [1:0] OP_GEN  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_PI_CODE          = 3'd0;
  localparam logic [2:0] CFG_TRAFFIC_PROGRAM  = 3'd1;
  localparam logic [2:0] CFG_PROGRAM_TYPE     = 3'd2;
  localparam logic [2:0] CFG_TRAFFIC_ANNOUNCE = 3'd3;
  localparam logic [2:0] CFG_MUSIC_SPEECH     = 3'd4;
  localparam logic [2:0] CFG_DECODER_INFO     = 3'd5;
  localparam logic [2:0] CFG_TEXT_AB_FLAG     = 3'd6;
  localparam logic [2:0] CFG_GROUP_RATIO      = 3'd7;

  localparam logic [7:0] GROUP_RATIO_RESET = 8'd8;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [15:0] GROUP_2A_TYPE = 16'h2000;
  localparam logic [15:0] NO_AF_FILLER  = 16'hE0CD;

  // low ten bits of g(x) = x^10 + x^8 + x^7 + x^5 + x^4 + x^3 + 1
  localparam logic [9:0] POLY_LOW = 10'h1B9;

  localparam logic [9:0] OFS_A = 10'h0FC;
  localparam logic [9:0] OFS_B = 10'h198;
  localparam logic [9:0] OFS_C = 10'h168;
  localparam logic [9:0] OFS_D = 10'h1B4;

  typedef logic [15:0][9:0] syn_table_t;
  typedef logic [25:0] rds_block_t;

  // x^(i+10) mod g(x) for each data bit i
  function automatic syn_table_t crc_syn_table();
    syn_table_t t;
    logic [9:0] r;
    r = POLY_LOW;
    for (int i = 0; i < 16; i++) begin
      t[i] = r;
      r = {r[8:0], 1'b0} ^ (r[9] ? POLY_LOW : 10'd0);
    end
    return t;
  endfunction

  localparam syn_table_t CRC_SYN = crc_syn_table();

  function automatic logic [9:0] crc10(input logic [15:0] data);
    logic [9:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (data[i]) begin
        r = r ^ CRC_SYN[i];
      end
    end
    return r;
  endfunction

  function automatic rds_block_t make_block(input logic [15:0] data, input logic [9:0] ofs);
    return {data, crc10(data) ^ ofs};
  endfunction

endpackage

// ===== design/rdsge_ram.sv =====
module rdsge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rdsge_text.sv =====
module rdsge_text #(
  parameter int TEXT_LEN = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [5:0]      wr_index,
  input  logic [7:0]      wr_char,
  input  logic [5:0]      rd_pos,
  output logic [3:0][7:0] rd_chars
);

  // four lanes, one character of each row of four per lane
  localparam int Rows   = (TEXT_LEN + 3) / 4;
  localparam int RowAw  = (Rows > 1) ? $clog2(Rows) : 1;

  logic [Rows-1:0][3:0] valid;
  logic [RowAw-1:0]     wr_row;
  logic [RowAw-1:0]     rd_row;
  logic [RowAw-1:0]     rd_row_q;
  logic                 wr_ok;
  logic [3:0][7:0]      ram_q;

  assign wr_ok  = wr_en && ({1'b0, wr_index} < 7'(TEXT_LEN));
  assign wr_row = wr_index[RowAw+1:2];
  assign rd_row = rd_pos[RowAw+1:2];

  for (genvar lane = 0; lane < 4; lane++) begin : g_lane
    rdsge_ram #(
      .WIDTH(8),
      .DEPTH(Rows)
    ) u_ram (
      .clk  (clk),
      .we   (wr_ok && (wr_index[1:0] == 2'(lane))),
      .waddr(wr_row),
      .wdata(wr_char),
      .raddr(rd_row),
      .rdata(ram_q[lane])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[wr_row][wr_index[1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_q <= rd_row;
  end

  // never-written characters read as carriage return
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_chars[k] = valid[rd_row_q][k] ? ram_q[k] : rdsge_pkg::CHAR_CR;
    end
  end

endmodule

// ===== design/rds_group_encoder.sv =====
// RDS group encoder, types 0A and 2A.
// Input words on s_t*: s_tuser is the kind (write name char, write text
// char, generate group); s_tdata carries the character index and byte.
// Write words store a character and give no output. A generate word gives
// one output word on m_t*: four 26-bit blocks in m_tdata (A lowest) and the
// 2A flag in m_tuser. Every group_ratio 0A groups are followed by one 2A,
// and a group_ratio of zero gives no 2A groups. Configuration goes through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. Throughput: one input word
// per cycle while s_tready is high. A generate word is taken into the compute
// stage, reading the radiotext memory at the accepting edge; when the output
// register is free, the four blocks with their check words are loaded into it.
// Reset clears the positions and group counter, sets the configuration to
// defaults, and makes the name read as spaces and the radiotext as carriage
// returns.
// When m_tready is low the output register holds its group; one more group
// waits in the compute stage, and after that s_tready drops until the
// receiver takes the output word.
module rds_group_encoder #(
  parameter int TEXT_LEN = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // char_index[5:0], char_value[13:6], zero fill
  input  logic [1:0]   s_tuser,   // op[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // block_a[25:0], block_b[51:26], block_c[77:52],
                                  // block_d[103:78]
  output logic         m_tuser,   // is_group_2a
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0] pi_code;
  logic        traffic_program;
  logic [4:0]  program_type;
  logic        traffic_announce;
  logic        music_speech;
  logic [3:0]  decoder_info;
  logic        text_ab_flag;
  logic [7:0]  group_ratio;

  logic [3:0][15:0] name_rows;
  logic [1:0]       name_seg;
  logic [5:0]       text_position;
  logic [7:0]       group_counter;

  logic        s1_valid;
  logic        s1_is2a;
  logic [1:0]  s1_seg;
  logic [15:0] s1_name;

  logic        accept;
  logic        s1_adv;
  logic [1:0]  op;
  logic [5:0]  char_index;
  logic [7:0]  char_value;
  logic        gen_is2a;
  logic        text_wrap;

  logic [3:0][7:0] text_chars;
  logic [15:0]     common;
  logic [15:0]     data_b;
  logic [15:0]     data_c;
  logic [15:0]     data_d;

  assign op         = s_tuser;
  assign char_index = s_tdata[5:0];
  assign char_value = s_tdata[13:6];

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign gen_is2a = (group_ratio != 8'd0) && (group_counter >= group_ratio);

  always_ff @(posedge clk) begin
    if (rst) begin
      pi_code          <= '0;
      traffic_program  <= 1'b0;
      program_type     <= '0;
      traffic_announce <= 1'b0;
      music_speech     <= 1'b0;
      decoder_info     <= '0;
      text_ab_flag     <= 1'b0;
      group_ratio      <= rdsge_pkg::GROUP_RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rdsge_pkg::CFG_PI_CODE:          pi_code          <= cfg_data;
        rdsge_pkg::CFG_TRAFFIC_PROGRAM:  traffic_program  <= cfg_data[0];
        rdsge_pkg::CFG_PROGRAM_TYPE:     program_type     <= cfg_data[4:0];
        rdsge_pkg::CFG_TRAFFIC_ANNOUNCE: traffic_announce <= cfg_data[0];
        rdsge_pkg::CFG_MUSIC_SPEECH:     music_speech     <= cfg_data[0];
        rdsge_pkg::CFG_DECODER_INFO:     decoder_info     <= cfg_data[3:0];
        rdsge_pkg::CFG_TEXT_AB_FLAG:     text_ab_flag     <= cfg_data[0];
        rdsge_pkg::CFG_GROUP_RATIO:      group_ratio      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // name: four segments of two characters, even index in the high byte
  always_ff @(posedge clk) begin
    if (rst) begin
      name_rows <= {4{rdsge_pkg::CHAR_SPACE, rdsge_pkg::CHAR_SPACE}};
    end else if (accept && (op == rdsge_pkg::OP_NAME) && (char_index[5:3] == 3'd0)) begin
      if (char_index[0]) begin
        name_rows[char_index[2:1]][7:0] <= char_value;
      end else begin
        name_rows[char_index[2:1]][15:8] <= char_value;
      end
    end
  end

  rdsge_text #(
    .TEXT_LEN(TEXT_LEN)
  ) u_text (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (op == rdsge_pkg::OP_TEXT)),
    .wr_index(char_index),
    .wr_char (char_value),
    .rd_pos  (text_position),
    .rd_chars(text_chars)
  );

  // group selection and name segment advance at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      group_counter <= '0;
      name_seg      <= '0;
    end else if (accept && (op == rdsge_pkg::OP_GEN)) begin
      if (gen_is2a) begin
        group_counter <= '0;
      end else begin
        name_seg <= name_seg + 2'd1;
        if (group_ratio != 8'd0) begin
          group_counter <= group_counter + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && (op == rdsge_pkg::OP_GEN)) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op == rdsge_pkg::OP_GEN)) begin
      s1_is2a <= gen_is2a;
      s1_seg  <= name_seg;
      s1_name <= name_rows[name_seg];
    end
  end

  // wrap after the buffer end or a carriage return in the last char sent
  assign text_wrap = ({1'b0, text_position} + 7'd4 >= 7'(TEXT_LEN)) ||
                     (text_chars[3] == rdsge_pkg::CHAR_CR);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position <= '0;
    end else if (s1_adv && s1_is2a) begin
      text_position <= text_wrap ? 6'd0 : text_position + 6'd4;
    end
  end

  assign common = {5'd0, traffic_program, program_type, 5'd0};

  always_comb begin
    if (s1_is2a) begin
      data_b = rdsge_pkg::GROUP_2A_TYPE | common |
               {11'd0, text_ab_flag, text_position[5:2]};
      data_c = {text_chars[0], text_chars[1]};
      data_d = {text_chars[2], text_chars[3]};
    end else begin
      data_b = common | {11'd0, traffic_announce, music_speech,
                         decoder_info[~s1_seg], s1_seg};
      data_c = rdsge_pkg::NO_AF_FILLER;
      data_d = s1_name;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tuser <= s1_is2a;
      m_tdata <= {rdsge_pkg::make_block(data_d, rdsge_pkg::OFS_D),
                  rdsge_pkg::make_block(data_c, rdsge_pkg::OFS_C),
                  rdsge_pkg::make_block(data_b, rdsge_pkg::OFS_B),
                  rdsge_pkg::make_block(pi_code, rdsge_pkg::OFS_A)};
    end
  end

endmodule

// ===== test/rds_group_checker.sv =====
`timescale 1ns / 1ps

module rds_group_checker #(
  parameter int TEXT_LEN = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [15:0]  s_tdata,   // char_index[5:0], char_value[13:6], zero fill
  input  logic [1:0]   s_tuser,   // op[1:0]
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,   // block_a[25:0], block_b[51:26], block_c[77:52],
                                  // block_d[103:78]
  input  logic         m_tuser,   // is_group_2a
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           errors,
  output int           pending,
  output int           groups_0a,
  output int           groups_2a
);

  typedef struct packed {
    logic                  is_2a;
    rdsge_pkg::rds_block_t a;
    rdsge_pkg::rds_block_t b;
    rdsge_pkg::rds_block_t c;
    rdsge_pkg::rds_block_t d;
  } rds_group_t;

  // shadow of the configuration registers
  logic [15:0] pi;
  logic        tp;
  logic [4:0]  pty;
  logic        ta;
  logic        ms;
  logic [3:0]  di;
  logic        ab;
  logic [7:0]  ratio;

  logic [7:0]  name_mem [8];
  logic [7:0]  text_mem [64];
  logic [2:0]  name_pos;
  logic [5:0]  text_pos;
  logic [7:0]  count;

  rds_group_t  expected_groups [$];
  rds_group_t  want;
  rds_group_t  got;
  int          err_count = 0;
  int          n0 = 0;
  int          n2 = 0;

  // serial division by g(x), then add the offset word
  function automatic rdsge_pkg::rds_block_t protect(input logic [15:0] data,
                                                    input logic [9:0] ofs);
    logic [9:0] rem;
    logic       fb;
    rem = '0;
    for (int i = 15; i >= 0; i--) begin
      fb  = rem[9] ^ data[i];
      rem = {rem[8:0], 1'b0};
      if (fb) begin
        rem = rem ^ rdsge_pkg::POLY_LOW;
      end
    end
    return {data, rem ^ ofs};
  endfunction

  function automatic logic [7:0] text_char(input int idx);
    if (idx >= TEXT_LEN || idx >= 64) begin
      return rdsge_pkg::CHAR_CR;
    end
    return text_mem[idx];
  endfunction

  task automatic encode_group(output rds_group_t g);
    logic        two_a;
    logic [1:0]  seg;
    logic [5:0]  p;
    int          last;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    if (ratio == 8'd0) begin
      two_a = 1'b0;
    end else if (count >= ratio) begin
      two_a = 1'b1;
      count = '0;
    end else begin
      two_a = 1'b0;
      count = count + 8'd1;
    end
    if (!two_a) begin
      seg      = name_pos[2:1];
      b        = {5'b0, tp, pty, ta, ms, di[3 - seg], seg};
      c        = rdsge_pkg::NO_AF_FILLER;
      d        = {name_mem[{seg, 1'b0}], name_mem[{seg, 1'b1}]};
      name_pos = {seg + 2'd1, 1'b0};
    end else begin
      p    = text_pos;
      last = int'(p) + 3;
      b    = rdsge_pkg::GROUP_2A_TYPE | {5'b0, tp, pty, ab, p[5:2]};
      c    = {text_char(int'(p)), text_char(int'(p) + 1)};
      d    = {text_char(int'(p) + 2), text_char(last)};
      // wrap at the buffer end or at a carriage return
      if (last >= TEXT_LEN - 1 || text_char(last) == rdsge_pkg::CHAR_CR) begin
        text_pos = '0;
      end else begin
        text_pos = p + 6'd4;
      end
    end
    g.is_2a = two_a;
    g.a     = protect(pi, rdsge_pkg::OFS_A);
    g.b     = protect(b, rdsge_pkg::OFS_B);
    g.c     = protect(c, rdsge_pkg::OFS_C);
    g.d     = protect(d, rdsge_pkg::OFS_D);
  endtask

  task automatic check_field(input string field, input logic [25:0] exp_v,
                             input logic [25:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      if (err_count <= 10) begin
        $display("group %0d, %s: expected %h, got %h", n0 + n2, field, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pi       = '0;
      tp       = 1'b0;
      pty      = '0;
      ta       = 1'b0;
      ms       = 1'b0;
      di       = '0;
      ab       = 1'b0;
      ratio    = rdsge_pkg::GROUP_RATIO_RESET;
      name_pos = '0;
      text_pos = '0;
      count    = '0;
      for (int i = 0; i < 8; i++) name_mem[i] = rdsge_pkg::CHAR_SPACE;
      for (int i = 0; i < 64; i++) text_mem[i] = rdsge_pkg::CHAR_CR;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rdsge_pkg::CFG_PI_CODE:          pi    = cfg_data;
          rdsge_pkg::CFG_TRAFFIC_PROGRAM:  tp    = cfg_data[0];
          rdsge_pkg::CFG_PROGRAM_TYPE:     pty   = cfg_data[4:0];
          rdsge_pkg::CFG_TRAFFIC_ANNOUNCE: ta    = cfg_data[0];
          rdsge_pkg::CFG_MUSIC_SPEECH:     ms    = cfg_data[0];
          rdsge_pkg::CFG_DECODER_INFO:     di    = cfg_data[3:0];
          rdsge_pkg::CFG_TEXT_AB_FLAG:     ab    = cfg_data[0];
          rdsge_pkg::CFG_GROUP_RATIO:      ratio = cfg_data[7:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        got.is_2a = m_tuser;
        got.a     = m_tdata[25:0];
        got.b     = m_tdata[51:26];
        got.c     = m_tdata[77:52];
        got.d     = m_tdata[103:78];
        if (expected_groups.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected group on output: tuser %b, tdata %h", m_tuser, m_tdata);
          end
        end else begin
          want = expected_groups.pop_front();
          check_field("is_group_2a", 26'(want.is_2a), 26'(got.is_2a));
          check_field("block_a", want.a, got.a);
          check_field("block_b", want.b, got.b);
          check_field("block_c", want.c, got.c);
          check_field("block_d", want.d, got.d);
          if (want.is_2a) n2++;
          else n0++;
        end
      end

      if (s_tvalid && s_tready) begin
        case (s_tuser)
          rdsge_pkg::OP_NAME: begin
            if (s_tdata[5:0] < 6'd8) name_mem[s_tdata[2:0]] = s_tdata[13:6];
          end
          rdsge_pkg::OP_TEXT: begin
            if (int'(s_tdata[5:0]) < TEXT_LEN) text_mem[s_tdata[5:0]] = s_tdata[13:6];
          end
          rdsge_pkg::OP_GEN: begin
            encode_group(want);
            expected_groups.push_back(want);
          end
          default: ;
        endcase
      end
    end
    errors    <= err_count;
    pending   <= expected_groups.size();
    groups_0a <= n0;
    groups_2a <= n2;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int TEXT_LEN = 64;
  localparam int LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PER_PHASE = 240;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata = '0;
  logic [1:0]   s_tuser = rdsge_pkg::OP_NAME;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = rdsge_pkg::CFG_PI_CODE;
  logic [15:0]  cfg_data = '0;

  int errors;
  int pending;
  int groups_0a;
  int groups_2a;
  bit stall_on = 1'b1;

  rds_group_encoder #(.TEXT_LEN(TEXT_LEN)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rds_group_checker #(.TEXT_LEN(TEXT_LEN)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .groups_0a(groups_0a), .groups_2a(groups_2a)
  );

  always #2 clk = ~clk;

  // receiver side: random back-pressure
  always @(posedge clk) begin
    m_tready <= !stall_on || ($urandom_range(99) >= 19);
  end

  task automatic push(input logic [1:0] op, input logic [5:0] idx, input logic [7:0] val);
    while (stall_on && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, val, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the sender until every group is out, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] pi, input logic tp, input logic [4:0] pty,
                            input logic ta, input logic ms, input logic [3:0] di,
                            input logic ab, input logic [7:0] ratio);
    logic [15:0] vals [8];
    vals[rdsge_pkg::CFG_PI_CODE]          = pi;
    vals[rdsge_pkg::CFG_TRAFFIC_PROGRAM]  = 16'(tp);
    vals[rdsge_pkg::CFG_PROGRAM_TYPE]     = 16'(pty);
    vals[rdsge_pkg::CFG_TRAFFIC_ANNOUNCE] = 16'(ta);
    vals[rdsge_pkg::CFG_MUSIC_SPEECH]     = 16'(ms);
    vals[rdsge_pkg::CFG_DECODER_INFO]     = 16'(di);
    vals[rdsge_pkg::CFG_TEXT_AB_FLAG]     = 16'(ab);
    vals[rdsge_pkg::CFG_GROUP_RATIO]      = 16'(ratio);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_word(inout int n);
    int          r;
    logic [5:0]  idx;
    logic [7:0]  val;
    r = $urandom_range(99);
    if (r < 45) begin
      push(rdsge_pkg::OP_GEN, 6'($urandom), 8'($urandom));
    end else if (r < 75) begin
      idx = 6'($urandom_range(0, TEXT_LEN - 1));
      // rare carriage returns let long runs of text build up
      val = ($urandom_range(99) < 6) ? rdsge_pkg::CHAR_CR : 8'($urandom);
      push(rdsge_pkg::OP_TEXT, idx, val);
    end else if (r < 95) begin
      idx = ($urandom_range(9) == 0) ? 6'($urandom_range(8, 63)) : 6'($urandom_range(0, 7));
      push(rdsge_pkg::OP_NAME, idx, 8'($urandom));
    end else begin
      push(OP_SPARE, 6'($urandom), 8'($urandom));
    end
    n++;
  endtask

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int n;
    logic [7:0] ratio;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: name and text extremes, ignored writes, one 2A group
    push(rdsge_pkg::OP_NAME, 6'd0, 8'hFF);
    push(rdsge_pkg::OP_NAME, 6'd7, 8'h00);
    push(rdsge_pkg::OP_NAME, 6'd8, 8'hAA);
    push(rdsge_pkg::OP_NAME, 6'd63, 8'h55);
    push(rdsge_pkg::OP_TEXT, 6'd0, 8'hFF);
    push(rdsge_pkg::OP_TEXT, 6'd63, 8'h00);
    push(rdsge_pkg::OP_TEXT, 6'd3, 8'h41);
    push(OP_SPARE, 6'd63, 8'hFF);
    for (int i = 0; i < 11; i++) begin
      push(rdsge_pkg::OP_GEN, (i % 2) ? 6'h3F : 6'h00, (i % 2) ? 8'hFF : 8'h00);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: set_config(16'h0000, 1'b0, 5'd0, 1'b0, 1'b0, 4'h0, 1'b0, 8'd0);
        1: set_config(16'hFFFF, 1'b1, 5'd31, 1'b1, 1'b1, 4'hF, 1'b1, 8'd255);
        default: begin
          // phase 2 drops the ratio under the count left by the previous phase
          ratio = (ph == 2) ? 8'd1 : (ph == 6) ? 8'($urandom_range(0, 4))
                                               : 8'($urandom_range(1, 6));
          set_config(16'($urandom), 1'($urandom), 5'($urandom), 1'($urandom),
                     1'($urandom), 4'($urandom), 1'($urandom), ratio);
        end
      endcase
      stall_on = (ph != 3);
      n = 0;
      while (n < PER_PHASE) random_word(n);
    end
    stall_on = 1'b1;

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d type 0A and %0d type 2A groups over %0d register settings",
             groups_0a, groups_2a, PHASES + 1);
    $display("with random stalls on both sides and one phase at full rate");
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d groups missing", errors, pending);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
